// ===== design/cpll_pkg.sv =====
// cpll_pkg: shared types, codes and tables for the carrier tracking PLL.
// No dependencies; used by every module of the block.
package cpll_pkg;

   // CORDIC datapath width and arctangent table length
   localparam int CW        = 34;
   localparam int TABLE_LEN = 24;
   localparam int STEP_W    = 5;

   localparam logic signed [CW-1:0] START_GAIN = 34'sd652032874;
   localparam logic [31:0]          HALF_TURN  = 32'h8000_0000;

   // configuration register indexes
   localparam int         CSR_IDX_W = 2;
   localparam logic [1:0] CSR_ALPHA = 2'd0;
   localparam logic [1:0] CSR_BETA  = 2'd1;
   localparam logic [1:0] CSR_MAXF  = 2'd2;
   localparam logic [1:0] CSR_MINF  = 2'd3;

   // multiplier operand selects
   typedef logic [2:0] mul_op_type;
   localparam mul_op_type MUL_NONE  = 3'd0;
   localparam mul_op_type MUL_EE    = 3'd1;
   localparam mul_op_type MUL_AVG   = 3'd2;
   localparam mul_op_type MUL_SQ    = 3'd3;
   localparam mul_op_type MUL_BETA  = 3'd4;
   localparam mul_op_type MUL_ALPHA = 3'd5;

   typedef struct packed {
      logic signed [15:0] sample_i;
      logic signed [15:0] sample_q;
   } req_type;

   typedef struct packed {
      logic signed [15:0] ref_cos;
      logic signed [15:0] ref_sin;
      logic [31:0]        avg_sq_error;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        alpha_gain;
      logic [23:0]        beta_gain;
      logic signed [31:0] freq_upper;
      logic signed [31:0] freq_lower;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic              iterate;
      logic [STEP_W-1:0] step;
      logic              take_err;
      mul_op_type        mul_op;
      logic              latch_sq;
      logic              start_acc;
      logic              add_acc;
      logic              take_fsum;
      logic              update;
      logic              emit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } status_type;

   // atan(2^-i) in Q0.32 turns
   function automatic logic [31:0] turn_atan(input logic [STEP_W-1:0] idx);
      logic [31:0] t;
      case (idx)
         5'd0:    t = 32'h2000_0000;
         5'd1:    t = 32'h12E4_051E;
         5'd2:    t = 32'h09FB_385B;
         5'd3:    t = 32'h0511_11D4;
         5'd4:    t = 32'h028B_0D43;
         5'd5:    t = 32'h0145_D7E1;
         5'd6:    t = 32'h00A2_F61E;
         5'd7:    t = 32'h0051_7C55;
         5'd8:    t = 32'h0028_BE53;
         5'd9:    t = 32'h0014_5F2F;
         5'd10:   t = 32'h000A_2F98;
         5'd11:   t = 32'h0005_17CC;
         5'd12:   t = 32'h0002_8BE6;
         5'd13:   t = 32'h0001_45F3;
         5'd14:   t = 32'h0000_A2FA;
         5'd15:   t = 32'h0000_517D;
         5'd16:   t = 32'h0000_28BE;
         5'd17:   t = 32'h0000_145F;
         5'd18:   t = 32'h0000_0A30;
         5'd19:   t = 32'h0000_0518;
         5'd20:   t = 32'h0000_028C;
         5'd21:   t = 32'h0000_0146;
         5'd22:   t = 32'h0000_00A3;
         5'd23:   t = 32'h0000_0051;
         default: t = 32'h0000_0000;
      endcase
      return t;
   endfunction

   // round at bit 15 and saturate to Q1.15
   function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      r = (v + CW'(16384)) >>> 15;
      if (r > CW'(32767))
         return 16'sh7FFF;
      else if (r < CW'(-32768))
         return -16'sh8000;
      return 16'(r);
   endfunction

endpackage

// ===== design/carrier_pll_ref_output.sv =====
// carrier_pll_ref_output: second-order carrier tracking PLL, top level.
// Depends on cpll_pkg, cpll_csr, cpll_ctrl and cpll_dp.
//
// Usage:
//   req_*  : one I/Q sample per item, taken when req_valid is high and
//            req_stall is low. req_stall is high while an item is in work.
//   rsp_*  : one item per sample: cos/sin of the NCO phase before the
//            update and the updated squared-error average. Held while
//            rsp_stall is high.
//   csr_*  : register writes (0 alpha, 1 beta, 2 max freq, 3 min freq),
//            always ready; write only while the loop is idle.
// Sequence: N = min(CORDIC_STAGES, 24). The rotation and vectoring CORDICs
//   iterate side by side for N steps, then the shared multiplier runs
//   five products, the loop state updates and the result is registered;
//   the next sample is taken only once the sequencer is idle again.
//   If the receiver stalls, the finished item waits in the sequencer
//   until the result register frees; the loop state is already updated.
// Reset: synchronous; clears phase, frequency, error average, registers
//   and the result valid.
module carrier_pll_ref_output #(
   parameter int SAMPLE_BITS   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cpll_pkg::req_type              req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cpll_pkg::rsp_type              rsp_item,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cpll_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);

   cpll_pkg::cfg_type    cfg;
   cpll_pkg::cmd_type    cmd;
   cpll_pkg::status_type status;

   cpll_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer: sets the command for every cycle of an item
   cpll_ctrl #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: CORDICs, multiplier, loop state, result register
   cpll_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .status    (status)
   );

endmodule

// ===== design/cpll_csr.sv =====
// cpll_csr: configuration registers (gains and frequency clamps).
// Depends on cpll_pkg.
module cpll_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cpll_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_data,
   output cpll_pkg::cfg_type                  cfg
);

   cpll_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cpll_pkg::CSR_ALPHA: cfg_in.alpha_gain = csr_data[15:0];
            cpll_pkg::CSR_BETA:  cfg_in.beta_gain  = csr_data[23:0];
            cpll_pkg::CSR_MAXF:  cfg_in.freq_upper = $signed(csr_data);
            cpll_pkg::CSR_MINF:  cfg_in.freq_lower = $signed(csr_data);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/cpll_ctrl.sv =====
// cpll_ctrl: sequencer for one item: CORDIC iterations, multiply steps,
// loop update and result hand-off. Depends on cpll_pkg.
module cpll_ctrl #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cpll_pkg::status_type   status,
   output cpll_pkg::cmd_type      cmd
);

   localparam int RUN_STEPS = (CORDIC_STAGES < cpll_pkg::TABLE_LEN) ?
                              CORDIC_STAGES : cpll_pkg::TABLE_LEN;
   localparam logic [cpll_pkg::STEP_W-1:0] LAST_STEP = cpll_pkg::STEP_W'(RUN_STEPS - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RUN  = 4'd1;
   localparam logic [3:0] S_ERR  = 4'd2;
   localparam logic [3:0] S_M0   = 4'd3;
   localparam logic [3:0] S_M1   = 4'd4;
   localparam logic [3:0] S_M2   = 4'd5;
   localparam logic [3:0] S_M3   = 4'd6;
   localparam logic [3:0] S_M4   = 4'd7;
   localparam logic [3:0] S_UPD  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0]                  state_ff, state_in;
   logic [cpll_pkg::STEP_W-1:0] step_ff, step_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.iterate = 1'b1;
            cmd.step    = step_ff;
            if (step_ff == LAST_STEP)
               state_in = S_ERR;
            else
               step_in = step_ff + 1'b1;
         end
         S_ERR: begin
            cmd.take_err = 1'b1;
            state_in     = S_M0;
         end
         S_M0: begin
            cmd.mul_op = cpll_pkg::MUL_EE;
            state_in   = S_M1;
         end
         S_M1: begin
            cmd.latch_sq = 1'b1;
            cmd.mul_op   = cpll_pkg::MUL_AVG;
            state_in     = S_M2;
         end
         S_M2: begin
            cmd.start_acc = 1'b1;
            cmd.mul_op    = cpll_pkg::MUL_SQ;
            state_in      = S_M3;
         end
         S_M3: begin
            cmd.add_acc = 1'b1;
            cmd.mul_op  = cpll_pkg::MUL_BETA;
            state_in    = S_M4;
         end
         S_M4: begin
            cmd.take_fsum = 1'b1;
            cmd.mul_op    = cpll_pkg::MUL_ALPHA;
            state_in      = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== design/cpll_dp.sv =====
// cpll_dp: loop datapath: two CORDIC engines stepped together, one shared
// multiplier, loop state and the result register. Depends on cpll_pkg.
module cpll_dp #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cpll_pkg::cmd_type      cmd,
   input  cpll_pkg::cfg_type      cfg,
   input  cpll_pkg::req_type      req_item,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output cpll_pkg::rsp_type      rsp_item,
   output cpll_pkg::status_type   status
);

   localparam int CW       = cpll_pkg::CW;
   localparam int SCALE_SH = 30 - SAMPLE_BITS;

   // rotation engine (NCO sin/cos)
   logic signed [CW-1:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic                 flip_ff, flip_in;
   // vectoring engine (sample angle)
   logic signed [CW-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [31:0]          vz_ff, vz_in;
   logic                 zero_ff, zero_in;
   // loop state
   logic [31:0]          phase_ff, phase_in;
   logic signed [31:0]   freq_ff, freq_in;
   logic [31:0]          avg_ff, avg_in;
   // post-processing
   logic signed [31:0]   err_ff, err_in;
   logic signed [15:0]   cos_ff, cos_in, sin_ff, sin_in;
   logic [31:0]          sq_ff, sq_in;
   logic [47:0]          acc_ff, acc_in;
   logic signed [65:0]   prod_ff, prod_in;
   logic signed [33:0]   fsum_ff, fsum_in;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   cpll_pkg::rsp_type    rsp_ff, rsp_in;

   logic                   flip_now;
   logic [31:0]            zf;
   logic [SAMPLE_BITS-1:0] si_low, sq_low;
   logic signed [CW-1:0]   xs, ys;
   logic [31:0]            atan_u;
   logic signed [CW-1:0]   atan_s;
   logic signed [CW-1:0]   rdx, rdy, vdx, vdy;
   logic [31:0]            angle;
   logic signed [32:0]     ma, mb;
   logic [16:0]            one_minus_a;

   // quadrants 1 and 2 rotate by a half turn first
   assign flip_now = phase_ff[31] ^ phase_ff[30];
   assign zf       = phase_ff ^ {flip_now, 31'd0};

   // only the low SAMPLE_BITS bits of each field count
   assign si_low = SAMPLE_BITS'($unsigned(req_item.sample_i));
   assign sq_low = SAMPLE_BITS'($unsigned(req_item.sample_q));
   assign xs     = CW'($signed(si_low)) <<< SCALE_SH;
   assign ys     = CW'($signed(sq_low)) <<< SCALE_SH;

   assign atan_u = cpll_pkg::turn_atan(cmd.step);
   assign atan_s = $signed({{(CW-32){1'b0}}, atan_u});
   assign rdx    = ry_ff >>> cmd.step;
   assign rdy    = rx_ff >>> cmd.step;
   assign vdx    = vy_ff >>> cmd.step;
   assign vdy    = vx_ff >>> cmd.step;

   assign angle       = zero_ff ? 32'd0 : vz_ff;
   assign one_minus_a = 17'h1_0000 - {1'b0, cfg.alpha_gain};

   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_ff;

   // shared multiplier operands
   always_comb begin
      unique case (cmd.mul_op)
         cpll_pkg::MUL_EE: begin
            ma = 33'(err_ff);
            mb = 33'(err_ff);
         end
         cpll_pkg::MUL_AVG: begin
            ma = $signed({16'd0, one_minus_a});
            mb = $signed({1'b0, avg_ff});
         end
         cpll_pkg::MUL_SQ: begin
            ma = $signed({17'd0, cfg.alpha_gain});
            mb = $signed({1'b0, sq_ff});
         end
         cpll_pkg::MUL_BETA: begin
            ma = $signed({9'd0, cfg.beta_gain});
            mb = 33'(err_ff);
         end
         cpll_pkg::MUL_ALPHA: begin
            ma = $signed({17'd0, cfg.alpha_gain});
            mb = 33'(err_ff);
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   always_comb begin
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rz_in        = rz_ff;
      flip_in      = flip_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      zero_in      = zero_ff;
      phase_in     = phase_ff;
      freq_in      = freq_ff;
      avg_in       = avg_ff;
      err_in       = err_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      fsum_in      = fsum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         rx_in   = cpll_pkg::START_GAIN;
         ry_in   = '0;
         rz_in   = CW'($signed(zf));
         flip_in = flip_now;
         zero_in = (si_low == '0) && (sq_low == '0);
         if (xs[CW-1]) begin
            vx_in = -xs;
            vy_in = -ys;
            vz_in = cpll_pkg::HALF_TURN;
         end else begin
            vx_in = xs;
            vy_in = ys;
            vz_in = '0;
         end
      end

      if (cmd.iterate) begin
         if (!rz_ff[CW-1]) begin
            rx_in = rx_ff - rdx;
            ry_in = ry_ff + rdy;
            rz_in = rz_ff - atan_s;
         end else begin
            rx_in = rx_ff + rdx;
            ry_in = ry_ff - rdy;
            rz_in = rz_ff + atan_s;
         end
         if (!vy_ff[CW-1]) begin
            vx_in = vx_ff + vdx;
            vy_in = vy_ff - vdy;
            vz_in = vz_ff + atan_u;
         end else begin
            vx_in = vx_ff - vdx;
            vy_in = vy_ff + vdy;
            vz_in = vz_ff - atan_u;
         end
      end

      if (cmd.take_err) begin
         err_in = $signed(angle - phase_ff);
         cos_in = cpll_pkg::to_q15(flip_ff ? -rx_ff : rx_ff);
         sin_in = cpll_pkg::to_q15(flip_ff ? -ry_ff : ry_ff);
      end

      if (cmd.mul_op != cpll_pkg::MUL_NONE)
         prod_in = 66'(ma) * 66'(mb);

      if (cmd.latch_sq)
         sq_in = prod_ff[63:32];
      if (cmd.start_acc)
         acc_in = prod_ff[47:0];
      if (cmd.add_acc)
         acc_in = acc_ff + prod_ff[47:0];
      if (cmd.take_fsum)
         fsum_in = 34'(freq_ff) + 34'($signed(prod_ff[56:24]));

      // prod_ff holds alpha * e here; bits 47:16 are the floored shift
      if (cmd.update) begin
         phase_in = phase_ff + fsum_ff[31:0] + prod_ff[47:16];
         avg_in   = acc_ff[47:16];
         if (fsum_ff > 34'(cfg.freq_upper))
            freq_in = cfg.freq_upper;
         else if (fsum_ff < 34'(cfg.freq_lower))
            freq_in = cfg.freq_lower;
         else
            freq_in = $signed(fsum_ff[31:0]);
      end

      if (cmd.emit) begin
         rsp_in.ref_cos      = cos_ff;
         rsp_in.ref_sin      = sin_ff;
         rsp_in.avg_sq_error = avg_ff;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         freq_ff      <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         freq_ff      <= freq_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rz_ff   <= rz_in;
      flip_ff <= flip_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      vz_ff   <= vz_in;
      zero_ff <= zero_in;
      err_ff  <= err_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      fsum_ff <= fsum_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== design/cpll_checker.sv =====
// cpll_checker: port-level assertions for the carrier PLL, with its bind.
// Depends on cpll_pkg and carrier_pll_ref_output.
module cpll_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input cpll_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cpll_pkg::rsp_type rsp_item
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed or dropped");

   // one item at a time: busy right after an acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // a new result never appears the cycle after a sample is taken
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // reset leaves the block idle with no result pending
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind carrier_pll_ref_output cpll_checker u_cpll_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for carrier_pll_ref_output with its own loop model.
// Depends on cpll_pkg (item types, register indexes) and the block's top level.
module tb;

   localparam int    PERIOD        = 12;
   localparam int    RESET_CYCLES  = 12;
   localparam int    SAMPLE_BITS   = 16;
   localparam int    CORDIC_STAGES = 16;
   localparam int    ATAN_LEN      = 24;
   localparam int    CYCLE_LIMIT   = 500_000;
   localparam int    DRAIN_CYCLES  = 64;
   localparam int    SEG_ITEMS     = 84;   // items per random setting
   localparam int    SEGS_PER_PH   = 4;
   localparam int    MAX_REPORTS   = 10;
   localparam longint SAMPLE_SCALE = 64'sd1 << (30 - SAMPLE_BITS);
   localparam longint ROT_GAIN     = 64'sd652032874;
   localparam real   TWO_PI        = 6.283185307179586;

   // which fields of a directed row carry a typed-in value
   localparam logic [2:0] PIN_NONE = 3'b000;
   localparam logic [2:0] PIN_COS  = 3'b001;
   localparam logic [2:0] PIN_SIN  = 3'b010;
   localparam logic [2:0] PIN_AVG  = 3'b100;

   // atan(2^-i) in 2^-32 turns, entry 0 in the top word
   localparam bit [ATAN_LEN*32-1:0] ATAN_TURN = {
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051};

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [1:0]        idx;
      logic [31:0]       data;
      cpll_pkg::req_type sample;
      logic [2:0]        pin;
      cpll_pkg::rsp_type pinned;
   } dir_row_type;

   // ---------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ---------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cpll_pkg::req_type req_item  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cpll_pkg::rsp_type rsp_item;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [cpll_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]       csr_data  = '0;

   // ---------------------------------------------------------------
   // bench state
   // ---------------------------------------------------------------
   int          cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          n_sent         = 0;
   int          n_checked      = 0;
   int          n_csr          = 0;
   int          n_settings     = 0;
   int          fail_count     = 0;

   // pin info of the item on the request bus, captured at acceptance
   logic [2:0]        cur_pin    = PIN_NONE;
   cpll_pkg::rsp_type cur_pinned = '0;

   // loop model: register copies and state
   logic [15:0] cfg_alpha = '0;
   logic [23:0] cfg_beta  = '0;
   int          cfg_max   = 0;
   int          cfg_min   = 0;
   logic [31:0] trk_phase = '0;
   longint      trk_freq  = 0;
   logic [31:0] trk_avg   = '0;

   cpll_pkg::rsp_type due_refs[$];   // reference items still to come, oldest first
   dir_row_type       dir_rows[$];

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   carrier_pll_ref_output #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------
   // loop model
   // ---------------------------------------------------------------
   function automatic longint atan_of(input int i);
      longint t;
      t = longint'(ATAN_TURN[(ATAN_LEN - 1 - i) * 32 +: 32]);
      return t;
   endfunction

   // round at bit 15, saturate to Q1.15
   function automatic logic signed [15:0] q15_of(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32767) r = 64'sd32767;
      else if (r < -64'sd32768) r = -64'sd32768;
      return r[15:0];
   endfunction

   // rotation CORDIC; quadrants 1 and 2 are folded by a half turn
   task automatic nco_cos_sin(input logic [31:0] ph,
                              output logic signed [15:0] c,
                              output logic signed [15:0] s);
      logic        flip;
      logic [31:0] zr;
      int          z32;
      longint      x, y, z, dx, dy;
      flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
      zr   = flip ? ph - cpll_pkg::HALF_TURN : ph;
      z32  = zr;
      z    = longint'(z32);
      x    = ROT_GAIN;
      y    = 0;
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_of(i);
         end else begin
            x = x + dx; y = y - dy; z = z + atan_of(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = q15_of(x);
      s = q15_of(y);
   endtask

   // vectoring CORDIC: angle of the sample in 2^-32 turns
   function automatic logic [31:0] sample_turns(input logic signed [15:0] si,
                                                input logic signed [15:0] sq);
      longint      x, y, dx, dy;
      logic [31:0] z;
      if (si == 0 && sq == 0) return 32'd0;   // zero sample has angle zero
      x = longint'(si) * SAMPLE_SCALE;
      y = longint'(sq) * SAMPLE_SCALE;
      z = 32'd0;
      if (x < 0) begin
         x = -x; y = -y; z = cpll_pkg::HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + 32'(atan_of(i));
         end else begin
            x = x - dx; y = y + dy; z = z - 32'(atan_of(i));
         end
      end
      return z;
   endfunction

   // one loop step: reference item for this sample, then state update
   task automatic track_sample(input cpll_pkg::req_type smp,
                               output cpll_pkg::rsp_type ref_out);
      logic signed [15:0] c, s;
      logic [31:0]        diff;
      int                 e32;
      longint             e, sq, a, b, avg, f, pa, hi, lo;
      nco_cos_sin(trk_phase, c, s);
      diff = sample_turns(smp.sample_i, smp.sample_q) - trk_phase;
      e32  = diff;          // half-turn error stays at its negative extreme
      e    = longint'(e32);
      a    = longint'(cfg_alpha);
      b    = longint'(cfg_beta);
      sq   = (e * e) >>> 32;
      avg  = ((64'sd65536 - a) * longint'(trk_avg) + a * sq) >>> 16;
      trk_avg = avg[31:0];
      f    = trk_freq + ((b * e) >>> 24);
      pa   = (a * e) >>> 16;
      trk_phase = trk_phase + f[31:0] + pa[31:0];
      hi   = longint'(cfg_max);
      lo   = longint'(cfg_min);
      // max test first, so crossed limits end on min only when not above max
      if (f > hi) f = hi;
      else if (f < lo) f = lo;
      trk_freq = f;
      ref_out.ref_cos      = c;
      ref_out.ref_sin      = s;
      ref_out.avg_sq_error = trk_avg;
   endtask

   // ---------------------------------------------------------------
   // monitor: all sampling at the rising edge, pre-edge values
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cpll_pkg::rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cpll_pkg::CSR_ALPHA: cfg_alpha = csr_data[15:0];
               cpll_pkg::CSR_BETA:  cfg_beta  = csr_data[23:0];
               cpll_pkg::CSR_MAXF:  cfg_max   = csr_data;
               cpll_pkg::CSR_MINF:  cfg_min   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            track_sample(req_item, want);
            if (cur_pin & PIN_COS) want.ref_cos      = cur_pinned.ref_cos;
            if (cur_pin & PIN_SIN) want.ref_sin      = cur_pinned.ref_sin;
            if (cur_pin & PIN_AVG) want.avg_sq_error = cur_pinned.avg_sq_error;
            due_refs.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_refs.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected item: cos %0d sin %0d avg %08h",
                           rsp_item.ref_cos, rsp_item.ref_sin, rsp_item.avg_sq_error);
            end else begin
               want = due_refs.pop_front();
               if (rsp_item !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"item %0d mismatch: want cos %0d sin %0d avg %08h,",
                               " got cos %0d sin %0d avg %08h"},
                              n_checked, want.ref_cos, want.ref_sin, want.avg_sq_error,
                              rsp_item.ref_cos, rsp_item.ref_sin, rsp_item.avg_sq_error);
               end
               n_checked++;
            end
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_stall = !reset && recv_stall_pct != 0 && ($urandom_range(99) < recv_stall_pct);

   // ---------------------------------------------------------------
   // drivers: all called and returning just after a falling edge
   // ---------------------------------------------------------------
   task automatic send_sample(input cpll_pkg::req_type smp, input logic [2:0] pin,
                              input cpll_pkg::rsp_type pinned);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_item   = smp;
      cur_pin    = pin;
      cur_pinned = pinned;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // wait until every reference item has come back
   task automatic drain;
      while (due_refs.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      n_csr++;
   endtask

   function automatic void add_csr(input logic [1:0] idx, input logic [31:0] data);
      dir_row_type r;
      r = '{ROW_CSR, idx, data, '0, PIN_NONE, '0};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_item(input logic signed [15:0] si,
                                    input logic signed [15:0] sq,
                                    input logic [2:0] pin,
                                    input cpll_pkg::rsp_type pinned);
      dir_row_type r;
      r = '{ROW_ITEM, cpll_pkg::CSR_ALPHA, 32'd0, '{si, sq}, pin, pinned};
      dir_rows.push_back(r);
   endfunction

   function automatic logic signed [15:0] clip16(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // new random setting of all four registers, loop idle
   task automatic pick_setting;
      logic [31:0] lim;
      drain;
      case ($urandom_range(3))
         0: write_csr(cpll_pkg::CSR_ALPHA, 32'd0);
         1: write_csr(cpll_pkg::CSR_ALPHA, 32'd65535);
         2: write_csr(cpll_pkg::CSR_ALPHA, $urandom_range(4096, 1));
         default: write_csr(cpll_pkg::CSR_ALPHA, $urandom & 32'hFFFF);
      endcase
      case ($urandom_range(3))
         0: write_csr(cpll_pkg::CSR_BETA, 32'd0);
         1: write_csr(cpll_pkg::CSR_BETA, 32'hFF_FFFF);
         2: write_csr(cpll_pkg::CSR_BETA, $urandom_range(65536, 1));
         default: write_csr(cpll_pkg::CSR_BETA, $urandom & 32'hFF_FFFF);
      endcase
      lim = $urandom_range(32'h4000_0000, 32'h0010_0000);
      case ($urandom_range(4))
         0: begin
            write_csr(cpll_pkg::CSR_MAXF, 32'h7FFF_FFFF);
            write_csr(cpll_pkg::CSR_MINF, 32'h8000_0000);
         end
         1: begin
            write_csr(cpll_pkg::CSR_MAXF, lim);
            write_csr(cpll_pkg::CSR_MINF, -lim);
         end
         2: begin   // crossed limits
            write_csr(cpll_pkg::CSR_MAXF, -lim);
            write_csr(cpll_pkg::CSR_MINF, lim);
         end
         3: begin
            write_csr(cpll_pkg::CSR_MAXF, 32'd0);
            write_csr(cpll_pkg::CSR_MINF, 32'd0);
         end
         default: begin
            write_csr(cpll_pkg::CSR_MAXF, $urandom);
            write_csr(cpll_pkg::CSR_MINF, $urandom);
         end
      endcase
      n_settings++;
   endtask

   // a carrier tone with noise, random offset frequency and rare phase slips
   task automatic send_tone(input int len);
      real               amp, turn, step, noise;
      cpll_pkg::req_type smp;
      amp   = ($urandom_range(3) == 0) ? 32767.0 : $itor($urandom_range(32767, 64));
      turn  = $itor($urandom_range(1_000_000)) / 1_000_000.0;
      step  = ($itor($urandom_range(4000)) - 2000.0) / 200_000.0;
      noise = amp * $itor($urandom_range(20)) / 200.0;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(49) == 0) turn = turn + 0.5;
         smp.sample_i = clip16($rtoi(amp * $cos(TWO_PI * turn)
                        + noise * ($itor($urandom_range(2000)) / 1000.0 - 1.0)));
         smp.sample_q = clip16($rtoi(amp * $sin(TWO_PI * turn)
                        + noise * ($itor($urandom_range(2000)) / 1000.0 - 1.0)));
         send_sample(smp, PIN_NONE, '0);
         turn = turn + step;
         if (turn >= 1.0) turn = turn - 1.0;
         if (turn < 0.0) turn = turn + 1.0;
      end
   endtask

   // raw full-range samples, sometimes with a zero or extreme component
   task automatic send_noise(input int len);
      cpll_pkg::req_type smp;
      for (int k = 0; k < len; k++) begin
         smp = $urandom;
         case ($urandom_range(7))
            0: smp.sample_i = '0;
            1: smp.sample_q = '0;
            2: smp = '0;
            3: smp.sample_i = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: ;
         endcase
         send_sample(smp, PIN_NONE, '0);
      end
   endtask

   // ---------------------------------------------------------------
   // timeout
   // ---------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d items still due",
               cycle_count, due_refs.size());
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      cpll_pkg::rsp_type at_rest;
      int                send_mix [4];
      int                recv_mix [4];
      int                seg_start, left, len;
      send_mix = '{0, 64, 0, 31};
      recv_mix = '{0, 0, 64, 31};
      // zero gains keep the phase at zero and the error average at zero
      at_rest  = '{16'sh7FFF, 16'sh0000, 32'd0};

      // directed table: reset gains, then extreme gains, then crossed limits
      add_csr(cpll_pkg::CSR_ALPHA, 32'd0);
      add_csr(cpll_pkg::CSR_BETA,  32'd0);
      add_csr(cpll_pkg::CSR_MAXF,  32'd0);
      add_csr(cpll_pkg::CSR_MINF,  32'd0);
      add_item(16'sd0,      16'sd0,      PIN_COS | PIN_AVG, at_rest);  // zero sample
      add_item(16'sd32767,  16'sd0,      PIN_COS | PIN_AVG, at_rest);
      add_item(-16'sd32768, 16'sd0,      PIN_COS | PIN_AVG, at_rest);  // near half turn
      add_item(16'sd0,      16'sd32767,  PIN_COS | PIN_AVG, at_rest);
      add_item(16'sd0,      -16'sd32768, PIN_COS | PIN_AVG, at_rest);
      add_item(16'sd32767,  16'sd32767,  PIN_COS | PIN_AVG, at_rest);
      add_item(-16'sd32768, -16'sd32768, PIN_COS | PIN_AVG, at_rest);
      add_item(-16'sd32768, 16'sd32767,  PIN_COS | PIN_AVG, at_rest);
      add_item(-16'sd1,     -16'sd1,     PIN_COS | PIN_AVG, at_rest);
      add_csr(cpll_pkg::CSR_ALPHA, 32'd65535);
      add_csr(cpll_pkg::CSR_BETA,  32'hFF_FFFF);
      add_csr(cpll_pkg::CSR_MAXF,  32'h7FFF_FFFF);
      add_csr(cpll_pkg::CSR_MINF,  32'h8000_0000);
      add_item(16'sd0,      16'sd32767,  PIN_NONE, '0);
      add_item(-16'sd32768, 16'sd0,      PIN_NONE, '0);
      add_item(16'sd32767,  -16'sd32768, PIN_NONE, '0);
      add_item(16'sd0,      16'sd0,      PIN_NONE, '0);
      add_item(-16'sd32768, -16'sd1,     PIN_NONE, '0);
      add_item(16'sd1,      16'sd0,      PIN_NONE, '0);
      add_item(16'sd0,      -16'sd1,     PIN_NONE, '0);
      add_item(16'sd12345,  -16'sd23456, PIN_NONE, '0);
      add_csr(cpll_pkg::CSR_MAXF,  -32'sd1000);    // crossed: min above max
      add_csr(cpll_pkg::CSR_MINF,  32'sd1000);
      add_csr(cpll_pkg::CSR_ALPHA, 32'd1);
      add_csr(cpll_pkg::CSR_BETA,  32'd1);
      add_item(16'sd0,      16'sd32767,  PIN_NONE, '0);
      add_item(16'sd0,      -16'sd32768, PIN_NONE, '0);
      add_item(-16'sd32768, 16'sd0,      PIN_NONE, '0);
      add_item(16'sd32767,  16'sd1,      PIN_NONE, '0);
      add_item(16'sd0,      16'sd0,      PIN_NONE, '0);

      // single reset at the start
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            drain;
            write_csr(dir_rows[r].idx, dir_rows[r].data);
         end else begin
            send_sample(dir_rows[r].sample, dir_rows[r].pin, dir_rows[r].pinned);
         end
      end
      n_settings = n_settings + 3;

      // random part: four idling mixes, several register settings each
      for (int ph = 0; ph < 4; ph++) begin
         drain;
         send_idle_pct  = send_mix[ph];
         recv_stall_pct = recv_mix[ph];
         for (int sg = 0; sg < SEGS_PER_PH; sg++) begin
            pick_setting;
            seg_start = n_sent;
            while (n_sent - seg_start < SEG_ITEMS) begin
               left = SEG_ITEMS - (n_sent - seg_start);
               if ($urandom_range(9) < 7) begin
                  len = $urandom_range(60, 10);
                  send_tone(len < left ? len : left);
               end else begin
                  len = $urandom_range(10, 1);
                  send_noise(len < left ? len : left);
               end
            end
         end
      end

      // let everything come back, then a few quiet cycles
      drain;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d samples over %0d register settings (%0d writes), %0d checked",
               n_sent, n_settings, n_csr, n_checked);
      $display("idling mixes: none, sender, receiver, both; %0d mismatches", fail_count);
      if (fail_count == 0 && due_refs.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/cpll_pkg.sv
design/cpll_csr.sv
design/cpll_ctrl.sv
design/cpll_dp.sv
design/carrier_pll_ref_output.sv
design/cpll_checker.sv
tb/tb.sv
